FILE: rtl/srcs_pkg.sv
`default_nettype none
package srcs_pkg;

   localparam int SAMPLE_W         = 24;
   localparam int CNT_OUT_W        = 17;
   localparam int NUM_CH           = 4;
   localparam int CH_W             = 2;
   localparam int NUM_REGS         = 7;
   localparam int REG_IDX_W        = 3;
   localparam int SQ_ACC_W         = 64;
   localparam int DEF_MAX_READINGS = 65536;

   // configuration register indexes
   localparam logic [REG_IDX_W-1:0] REG_TEMP_UPPER  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_TEMP_LOWER  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_PRESS_UPPER = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_PRESS_LOWER = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_VIB_UPPER   = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_SPEED_UPPER = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_SPEED_LOWER = 3'd6;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   localparam sample_type REG_RESET [NUM_REGS] = '{
      24'sd217600, -24'sd10240, 24'sd30720, 24'sd128,
      24'sd3840, 24'sd3840000, 24'sd256000
   };

   localparam logic KIND_VERDICT = 1'b0;
   localparam logic KIND_STATS   = 1'b1;

   typedef struct packed {
      sample_type temperature;
      sample_type pressure;
      sample_type vibration;
      sample_type shaft_speed;
      logic       final_reading;
   } req_type;

   typedef struct packed {
      logic                 result_kind;
      logic [NUM_CH-1:0]    channel_flags;
      logic                 any_out_of_range;
      logic [CH_W-1:0]      channel;
      sample_type           ch_min;
      sample_type           ch_max;
      sample_type           ch_mean;
      logic [SAMPLE_W-1:0]  ch_rms;
      logic [CNT_OUT_W-1:0] ch_anomalies;
      logic [CNT_OUT_W-1:0] reading_count;
      logic [CNT_OUT_W-1:0] out_of_range_total;
      logic                 last_result;
   } rsp_type;

   typedef struct packed {
      logic accum;
      logic first;
      logic clear;
   } lane_ctl_type;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_SETTLE,
      ST_START,
      ST_CALC
   } ctrl_state_type;

   typedef enum logic [1:0] {
      DSQ_IDLE,
      DSQ_DIV,
      DSQ_ROOT
   } dsq_state_type;

endpackage
`default_nettype wire

FILE: rtl/srcs_if.sv
`default_nettype none
interface srcs_req_if;
   import srcs_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface srcs_rsp_if;
   import srcs_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/sensor_range_check_running_stats.sv
// Sensor window check with batch statistics.
// req_chan carries one reading of four channels (temperature, pressure,
// vibration, shaft speed) plus a final_reading mark; rsp_chan returns results.
// Each reading gives one verdict transaction, registered: it is offered the
// cycle after the reading is accepted. A reading marked final is followed by
// four channel statistics transactions (min, max, mean, rms, anomaly counts),
// then all accumulators clear for the next batch.
// Throughput: one reading per cycle while the verdict register is free or
// being drained. After a final reading the four channel lanes are read out
// one at a time through a shared divide and square-root unit (64 quotient steps,
// then 32 root steps, per channel); no reading is taken until the last channel
// result is loaded. A stalled rsp_chan holds its result and stops intake once
// the output register is full. Limits are written through csr_we, csr_index and
// csr_wdata; the user must write them only while idle, as the block does not
// enforce it. Synchronous reset restores default limits and clears the batch.
`default_nettype none
module sensor_range_check_running_stats #(
   parameter int MAX_READINGS = srcs_pkg::DEF_MAX_READINGS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   srcs_req_if.sink                            req_chan,
   srcs_rsp_if.source                          rsp_chan,
   input  wire logic                           csr_we,
   input  wire logic [srcs_pkg::REG_IDX_W-1:0] csr_index,
   input  wire logic [srcs_pkg::SAMPLE_W-1:0]  csr_wdata
);
   import srcs_pkg::*;

   localparam int CNT_W = $clog2(MAX_READINGS + 1);
   localparam int SUM_W = SAMPLE_W + CNT_W;

   sample_type               limit_ff [NUM_REGS];
   ctrl_state_type           state_ff, state_in;
   logic [CH_W-1:0]          ch_ff, ch_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         faults_ff, faults_in;
   logic                     out_vld_ff, out_vld_in;
   rsp_type                  out_ff, out_in;

   logic                     accept, load_verdict, load_stat, dsq_start, dsq_busy;
   logic                     batch_clear;
   lane_ctl_type             lane_ctl;
   sample_type               samp [NUM_CH];
   sample_type               upper [NUM_CH];
   sample_type               lower [NUM_CH];
   logic [NUM_CH-1:0]        flags;
   sample_type               lane_min [NUM_CH];
   sample_type               lane_max [NUM_CH];
   logic signed [SUM_W-1:0]  lane_sum [NUM_CH];
   logic [SQ_ACC_W-1:0]      lane_sumsq [NUM_CH];
   logic [CNT_W-1:0]         lane_faults [NUM_CH];
   sample_type               dsq_mean;
   logic [SAMPLE_W-1:0]      dsq_rms;
   logic [CNT_W+CNT_OUT_W-1:0] cnt_next_x, flt_next_x, cnt_x, flt_x, lane_flt_x;

   // configuration registers; indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) limit_ff[i] <= REG_RESET[i];
      end else if (csr_we && (csr_index < REG_IDX_W'(NUM_REGS))) begin
         limit_ff[csr_index] <= csr_wdata;
      end
   end

   assign samp[0]  = req_chan.data.temperature;
   assign samp[1]  = req_chan.data.pressure;
   assign samp[2]  = req_chan.data.vibration;
   assign samp[3]  = req_chan.data.shaft_speed;
   assign upper[0] = limit_ff[REG_TEMP_UPPER];
   assign lower[0] = limit_ff[REG_TEMP_LOWER];
   assign upper[1] = limit_ff[REG_PRESS_UPPER];
   assign lower[1] = limit_ff[REG_PRESS_LOWER];
   assign upper[2] = limit_ff[REG_VIB_UPPER];
   assign lower[2] = '0;
   assign upper[3] = limit_ff[REG_SPEED_UPPER];
   assign lower[3] = limit_ff[REG_SPEED_LOWER];

   // one lane per channel
   for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
      srcs_lane #(
         .HAS_LOWER (c != 2),
         .SUM_W     (SUM_W),
         .CNT_W     (CNT_W)
      ) u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctl      (lane_ctl),
         .sample   (samp[c]),
         .upper    (upper[c]),
         .lower    (lower[c]),
         .flag     (flags[c]),
         .min_o    (lane_min[c]),
         .max_o    (lane_max[c]),
         .sum_o    (lane_sum[c]),
         .sumsq_o  (lane_sumsq[c]),
         .faults_o (lane_faults[c])
      );
   end

   srcs_divsqrt #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_divsqrt (
      .clock (clock),
      .reset (reset),
      .start (dsq_start),
      .sum   (lane_sum[ch_ff]),
      .sumsq (lane_sumsq[ch_ff]),
      .count (count_ff),
      .busy  (dsq_busy),
      .mean  (dsq_mean),
      .rms   (dsq_rms)
   );

   // sequence readings and the end-of-batch readout
   always_comb begin
      state_in       = state_ff;
      ch_in          = ch_ff;
      req_chan.ready = 1'b0;
      load_verdict   = 1'b0;
      load_stat      = 1'b0;
      dsq_start      = 1'b0;
      batch_clear    = 1'b0;
      unique case (state_ff)
         ST_RUN: begin
            req_chan.ready = !out_vld_ff || rsp_chan.ready;
            if (req_chan.valid && req_chan.ready) begin
               load_verdict = 1'b1;
               if (req_chan.data.final_reading) begin
                  state_in = ST_SETTLE;
                  ch_in    = '0;
               end
            end
         end
         ST_SETTLE: state_in = ST_START;
         ST_START: begin
            dsq_start = 1'b1;
            state_in  = ST_CALC;
         end
         ST_CALC: begin
            if (!dsq_busy && (!out_vld_ff || rsp_chan.ready)) begin
               load_stat = 1'b1;
               if (ch_ff == CH_W'(NUM_CH - 1)) begin
                  batch_clear = 1'b1;
                  state_in    = ST_RUN;
               end else begin
                  ch_in    = ch_ff + 1'b1;
                  state_in = ST_START;
               end
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   assign accept         = load_verdict;
   assign lane_ctl.clear = batch_clear;
   assign lane_ctl.accum = accept && (count_ff < CNT_W'(MAX_READINGS));
   assign lane_ctl.first = (count_ff == '0);

   // batch counters
   always_comb begin
      count_in  = count_ff;
      faults_in = faults_ff;
      if (lane_ctl.clear) begin
         count_in  = '0;
         faults_in = '0;
      end else if (lane_ctl.accum) begin
         count_in = count_ff + 1'b1;
         if (flags != '0) faults_in = faults_ff + 1'b1;
      end
   end

   assign cnt_next_x = {{CNT_OUT_W{1'b0}}, count_in};
   assign flt_next_x = {{CNT_OUT_W{1'b0}}, faults_in};
   assign cnt_x      = {{CNT_OUT_W{1'b0}}, count_ff};
   assign flt_x      = {{CNT_OUT_W{1'b0}}, faults_ff};
   assign lane_flt_x = {{CNT_OUT_W{1'b0}}, lane_faults[ch_ff]};

   // output register: load verdicts and channel results, drop on transaction
   always_comb begin
      out_in     = out_ff;
      out_vld_in = out_vld_ff;
      if (out_vld_ff && rsp_chan.ready) out_vld_in = 1'b0;
      if (load_verdict) begin
         out_vld_in                = 1'b1;
         out_in                    = '0;
         out_in.result_kind        = KIND_VERDICT;
         out_in.channel_flags      = flags;
         out_in.any_out_of_range   = (flags != '0);
         out_in.reading_count      = cnt_next_x[CNT_OUT_W-1:0];
         out_in.out_of_range_total = flt_next_x[CNT_OUT_W-1:0];
         out_in.last_result        = !req_chan.data.final_reading;
      end else if (load_stat) begin
         out_vld_in                = 1'b1;
         out_in                    = '0;
         out_in.result_kind        = KIND_STATS;
         out_in.channel            = ch_ff;
         out_in.ch_min             = lane_min[ch_ff];
         out_in.ch_max             = lane_max[ch_ff];
         out_in.ch_mean            = dsq_mean;
         out_in.ch_rms             = dsq_rms;
         out_in.ch_anomalies       = lane_flt_x[CNT_OUT_W-1:0];
         out_in.reading_count      = cnt_x[CNT_OUT_W-1:0];
         out_in.out_of_range_total = flt_x[CNT_OUT_W-1:0];
         out_in.last_result        = (ch_ff == CH_W'(NUM_CH - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_RUN;
         ch_ff      <= '0;
         count_ff   <= '0;
         faults_ff  <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ch_ff      <= ch_in;
         count_ff   <= count_in;
         faults_ff  <= faults_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_chan.valid = out_vld_ff;
   assign rsp_chan.data  = out_ff;

   // readings enter only while streaming
   a_accept_in_run: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |-> (state_ff == ST_RUN))
      else $error("reading accepted outside streaming state");

   // a final reading starts the readout
   a_final_readout: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.data.final_reading)
      |=> (state_ff == ST_SETTLE))
      else $error("final reading did not start readout");

   // the batch count saturates at its limit
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= CNT_W'(MAX_READINGS)))
      else $error("reading count past limit");

   // a channel result waits for the divide and root unit
   a_stat_after_calc: assert property (@(posedge clock) disable iff (reset)
      load_stat |-> ($past(state_ff) == ST_START || $past(state_ff) == ST_CALC))
      else $error("channel result loaded without a calculation");

endmodule
`default_nettype wire

FILE: rtl/srcs_lane.sv
`default_nettype none
module srcs_lane #(
   parameter bit HAS_LOWER = 1'b1,
   parameter int SUM_W     = 41,
   parameter int CNT_W     = 17
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire srcs_pkg::lane_ctl_type ctl,
   input  wire srcs_pkg::sample_type   sample,
   input  wire srcs_pkg::sample_type   upper,
   input  wire srcs_pkg::sample_type   lower,
   output logic                        flag,
   output srcs_pkg::sample_type        min_o,
   output srcs_pkg::sample_type        max_o,
   output logic signed [SUM_W-1:0]     sum_o,
   output logic [srcs_pkg::SQ_ACC_W-1:0] sumsq_o,
   output logic [CNT_W-1:0]            faults_o
);
   import srcs_pkg::*;

   sample_type                 min_ff, min_in;
   sample_type                 max_ff, max_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic [SQ_ACC_W-1:0]        sumsq_ff, sumsq_in;
   logic [CNT_W-1:0]           faults_ff, faults_in;
   logic [2*SAMPLE_W-1:0]      sq_ff, sq_in;
   logic                       sq_vld_ff, sq_vld_in;
   logic [SAMPLE_W-1:0]        mag;

   // strict window check
   assign flag = (sample > upper) || (HAS_LOWER && (sample < lower));

   assign mag   = sample[SAMPLE_W-1] ? (~sample + 1'b1) : sample;
   assign sq_in = (2*SAMPLE_W)'(mag) * (2*SAMPLE_W)'(mag);
   assign sq_vld_in = ctl.accum;

   // update running statistics
   always_comb begin
      min_in    = min_ff;
      max_in    = max_ff;
      sum_in    = sum_ff;
      faults_in = faults_ff;
      sumsq_in  = sumsq_ff;
      if (sq_vld_ff) begin
         sumsq_in = sumsq_ff + SQ_ACC_W'(sq_ff);
      end
      if (ctl.clear) begin
         min_in    = '0;
         max_in    = '0;
         sum_in    = '0;
         sumsq_in  = '0;
         faults_in = '0;
      end else if (ctl.accum) begin
         if (ctl.first || sample < min_ff) min_in = sample;
         if (ctl.first || sample > max_ff) max_in = sample;
         sum_in = sum_ff + SUM_W'(sample);
         if (flag) faults_in = faults_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff    <= '0;
         max_ff    <= '0;
         sum_ff    <= '0;
         sumsq_ff  <= '0;
         faults_ff <= '0;
         sq_vld_ff <= 1'b0;
      end else begin
         min_ff    <= min_in;
         max_ff    <= max_in;
         sum_ff    <= sum_in;
         sumsq_ff  <= sumsq_in;
         faults_ff <= faults_in;
         sq_vld_ff <= sq_vld_in;
      end
   end

   // hold the square for the next cycle's add
   always_ff @(posedge clock) begin
      sq_ff <= sq_in;
   end

   assign min_o    = min_ff;
   assign max_o    = max_ff;
   assign sum_o    = sum_ff;
   assign sumsq_o  = sumsq_ff;
   assign faults_o = faults_ff;

endmodule
`default_nettype wire

FILE: rtl/srcs_divsqrt.sv
`default_nettype none
module srcs_divsqrt #(
   parameter int SUM_W = 41,
   parameter int CNT_W = 17
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic signed [SUM_W-1:0]       sum,
   input  wire logic [srcs_pkg::SQ_ACC_W-1:0] sumsq,
   input  wire logic [CNT_W-1:0]              count,
   output logic                               busy,
   output srcs_pkg::sample_type               mean,
   output logic [srcs_pkg::SAMPLE_W-1:0]      rms
);
   import srcs_pkg::*;

   localparam int STEP_W = $clog2(SQ_ACC_W);
   localparam int ROOT_W = SQ_ACC_W / 2;
   localparam int REM_W  = ROOT_W + 2;

   dsq_state_type         state_ff, state_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  neg_ff, neg_in;
   logic                  zero_ff, zero_in;
   logic [SQ_ACC_W-1:0]   a_ff, a_in;
   logic [SQ_ACC_W-1:0]   b_ff, b_in;
   logic [CNT_W:0]        ra_ff, ra_in;
   logic [CNT_W:0]        rb_ff, rb_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [ROOT_W-1:0]     root_ff, root_in;

   logic [SUM_W-1:0]      sum_mag;
   logic [CNT_W:0]        ra_sh, rb_sh;
   logic [REM_W+1:0]      rem_sh, trial;

   assign sum_mag = sum[SUM_W-1] ? (~sum + 1'b1) : sum;
   assign ra_sh   = {ra_ff[CNT_W-1:0], a_ff[SQ_ACC_W-1]};
   assign rb_sh   = {rb_ff[CNT_W-1:0], b_ff[SQ_ACC_W-1]};
   assign rem_sh  = {rem_ff, b_ff[SQ_ACC_W-1 -: 2]};
   assign trial   = {2'b00, root_ff, 2'b01};

   // one quotient bit per cycle for both divisions, then two radicand bits per cycle
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      zero_in  = zero_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      ra_in    = ra_ff;
      rb_in    = rb_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      unique case (state_ff)
         DSQ_IDLE: begin
            if (start) begin
               state_in = DSQ_DIV;
               step_in  = STEP_W'(SQ_ACC_W - 1);
               cnt_in   = count;
               neg_in   = sum[SUM_W-1];
               zero_in  = (count == '0);
               a_in     = SQ_ACC_W'(sum_mag);
               b_in     = sumsq;
               ra_in    = '0;
               rb_in    = '0;
            end
         end
         DSQ_DIV: begin
            if (ra_sh >= {1'b0, cnt_ff}) begin
               ra_in = ra_sh - {1'b0, cnt_ff};
               a_in  = {a_ff[SQ_ACC_W-2:0], 1'b1};
            end else begin
               ra_in = ra_sh;
               a_in  = {a_ff[SQ_ACC_W-2:0], 1'b0};
            end
            if (rb_sh >= {1'b0, cnt_ff}) begin
               rb_in = rb_sh - {1'b0, cnt_ff};
               b_in  = {b_ff[SQ_ACC_W-2:0], 1'b1};
            end else begin
               rb_in = rb_sh;
               b_in  = {b_ff[SQ_ACC_W-2:0], 1'b0};
            end
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = DSQ_ROOT;
               step_in  = STEP_W'(ROOT_W - 1);
               rem_in   = '0;
               root_in  = '0;
            end
         end
         DSQ_ROOT: begin
            b_in = {b_ff[SQ_ACC_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_in  = REM_W'(rem_sh - trial);
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = REM_W'(rem_sh);
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            step_in = step_ff - 1'b1;
            if (step_ff == '0) state_in = DSQ_IDLE;
         end
         default: state_in = DSQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DSQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      ra_ff   <= ra_in;
      rb_ff   <= rb_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   // restore the sign of the mean, force zero for an empty batch
   assign busy = (state_ff != DSQ_IDLE);
   assign mean = zero_ff ? '0 :
                 neg_ff ? (~a_ff[SAMPLE_W-1:0] + 1'b1) : a_ff[SAMPLE_W-1:0];
   assign rms  = zero_ff ? '0 : root_ff[SAMPLE_W-1:0];

endmodule
`default_nettype wire
